>>> rtl/dsed_pkg.sv
// ----------------------------------------------------------------------------
// dsed_pkg
// Shared constants and types of the delayed slope event detector.
// ----------------------------------------------------------------------------
`default_nettype none

package dsed_pkg;

   // ring depth, a power of two; the delay line holds depth - 1 past samples
   localparam int RING_DEPTH = 32;
   localparam int TAP_W      = $clog2(RING_DEPTH);
   localparam int CELL_COUNT = RING_DEPTH - 1;

   localparam int SAMPLE_W = 16;
   localparam int INDEX_W  = 32;
   localparam int LEN_W    = 16;
   localparam int DELAY_W  = 5;

   localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(10);
   localparam logic [LEN_W-1:0]   RUN_MAX     = {LEN_W{1'b1}};

   // one detected event
   typedef struct packed {
      logic [INDEX_W-1:0]         sample_index;
      logic [LEN_W-1:0]           run_length;
      logic signed [SAMPLE_W-1:0] start_level;
      logic signed [SAMPLE_W-1:0] end_level;
   } evt_type;

   // run tracker status
   typedef struct packed {
      logic             fill;
      logic             open;
      logic [LEN_W-1:0] count;
   } run_status_type;

endpackage

`default_nettype wire

>>> rtl/delayed_slope_event_detector.sv
// ----------------------------------------------------------------------------
// delayed_slope_event_detector
// Compares each sample with the one taken delay samples earlier and reports
// one event per closed rising run.
// ----------------------------------------------------------------------------
// an event closing a run is registered in the output register or skid entry
// one sample per unstalled cycle; compare and run update are combinational
// behind the delay line of cells, results leave through a two-entry buffer
// req_stall rises only while both buffer entries hold an undelivered item
// reset (synchronous): sample index, run state and buffer cleared, delay 10;
// the delay line is not cleared, its first delay samples only fill it
`default_nettype none

module delayed_slope_event_detector (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // configuration
   input  wire logic                                  csr_wr_en,
   input  wire logic [dsed_pkg::DELAY_W-1:0]          csr_wr_data,
   // sample input
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [dsed_pkg::SAMPLE_W-1:0]  req_sample,
   // event output
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [dsed_pkg::INDEX_W-1:0]               rsp_sample_index,
   output logic [dsed_pkg::LEN_W-1:0]                 rsp_run_length,
   output logic signed [dsed_pkg::SAMPLE_W-1:0]       rsp_start_level,
   output logic signed [dsed_pkg::SAMPLE_W-1:0]       rsp_end_level
);
   import dsed_pkg::*;

   logic [DELAY_W-1:0]         delay_ff, delay_in;
   logic                       accept;
   logic [TAP_W-1:0]           back;
   logic signed [SAMPLE_W-1:0] chain [0:CELL_COUNT];
   logic signed [SAMPLE_W-1:0] taps  [1:CELL_COUNT];
   logic signed [SAMPLE_W-1:0] tap_sel;
   logic signed [SAMPLE_W-1:0] old_sample;
   logic                       evt_valid;
   evt_type                    evt;
   evt_type                    rsp_evt;
   run_status_type             status;
   logic                       buf_full;

   // delay register; the user must write it only while idle, the block does not enforce this
   assign delay_in = csr_wr_en ? csr_wr_data : delay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= DELAY_RESET;
      end else begin
         delay_ff <= delay_in;
      end
   end

   assign req_stall = buf_full;
   assign accept    = req_valid && !req_stall;

   // ring depth is a power of two, so the distance mod depth is the low bits
   assign back = TAP_W'(delay_ff);

   // delay line: cell k holds the sample accepted k items ago
   assign chain[0] = req_sample;

   for (genvar k = 1; k <= CELL_COUNT; k++) begin : g_cell
      dsed_cell u_cell (
         .clock      (clock),
         .shift_en   (accept),
         .cell_index (TAP_W'(k)),
         .back       (back),
         .d_in       (chain[k-1]),
         .d_out      (chain[k]),
         .tap_out    (taps[k])
      );
   end

   // at most one cell drives a non-zero tap
   always_comb begin
      tap_sel = '0;
      for (int k = 1; k <= CELL_COUNT; k++) begin
         tap_sel = tap_sel | taps[k];
      end
   end

   // a distance of zero compares the sample with itself, so it never rises
   assign old_sample = (back == '0) ? req_sample : tap_sel;

   dsed_run u_run (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .delay      (delay_ff),
      .sample     (req_sample),
      .old_sample (old_sample),
      .evt_valid  (evt_valid),
      .evt        (evt),
      .status     (status)
   );

   dsed_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .evt_valid (evt_valid),
      .evt       (evt),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_evt   (rsp_evt),
      .full      (buf_full)
   );

   assign rsp_sample_index = rsp_evt.sample_index;
   assign rsp_run_length   = rsp_evt.run_length;
   assign rsp_start_level  = rsp_evt.start_level;
   assign rsp_end_level    = rsp_evt.end_level;

   // a held skid entry always sits behind a valid output register
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("skid entry held with empty output register");

   // a run is open exactly while its length is non-zero
   a_open_count : assert property (@(posedge clock) disable iff (reset)
      status.open == (status.count != '0))
      else $error("run open flag and run length disagree");

   // fill samples never close a run
   a_no_evt_in_fill : assert property (@(posedge clock) disable iff (reset)
      (accept && status.fill) |-> !evt_valid)
      else $error("event raised during fill");

   // after a new event, the output register holds a valid item next cycle
   a_evt_shown : assert property (@(posedge clock) disable iff (reset)
      evt_valid |=> rsp_valid)
      else $error("event lost on the way to the output");

endmodule

`default_nettype wire

>>> rtl/dsed_cell.sv
// ----------------------------------------------------------------------------
// dsed_cell
// One delay cell: holds a past sample, hands it on and offers it as a tap.
// ----------------------------------------------------------------------------
`default_nettype none

module dsed_cell (
   input  wire logic                                  clock,
   input  wire logic                                  shift_en,
   input  wire logic [dsed_pkg::TAP_W-1:0]            cell_index,
   input  wire logic [dsed_pkg::TAP_W-1:0]            back,
   input  wire logic signed [dsed_pkg::SAMPLE_W-1:0]  d_in,
   output logic signed [dsed_pkg::SAMPLE_W-1:0]       d_out,
   output logic signed [dsed_pkg::SAMPLE_W-1:0]       tap_out
);
   import dsed_pkg::*;

   logic signed [SAMPLE_W-1:0] data_ff;
   logic signed [SAMPLE_W-1:0] data_in;

   assign data_in = shift_en ? d_in : data_ff;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign d_out   = data_ff;
   // only the cell at the selected distance drives its sample
   assign tap_out = (cell_index == back) ? data_ff : '0;

endmodule

`default_nettype wire

>>> rtl/dsed_run.sv
// ----------------------------------------------------------------------------
// dsed_run
// Sample counter and run tracker; flags an event when a run closes.
// ----------------------------------------------------------------------------
`default_nettype none

module dsed_run (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  accept,
   input  wire logic [dsed_pkg::DELAY_W-1:0]          delay,
   input  wire logic signed [dsed_pkg::SAMPLE_W-1:0]  sample,
   input  wire logic signed [dsed_pkg::SAMPLE_W-1:0]  old_sample,
   output logic                                       evt_valid,
   output dsed_pkg::evt_type                          evt,
   output dsed_pkg::run_status_type                   status
);
   import dsed_pkg::*;

   logic [INDEX_W-1:0]         count_ff,  count_in;
   logic [LEN_W-1:0]           run_ff,    run_in;
   logic signed [SAMPLE_W-1:0] start_ff,  start_in;
   logic                       open_ff,   open_in;
   logic                       fill;
   logic                       rise;

   assign fill = count_ff < INDEX_W'(delay);
   assign rise = sample > old_sample;

   always_comb begin
      count_in  = count_ff;
      run_in    = run_ff;
      start_in  = start_ff;
      open_in   = open_ff;
      evt_valid = 1'b0;
      if (accept) begin
         count_in = count_ff + INDEX_W'(1);
         if (!fill) begin
            if (rise) begin
               if (run_ff == '0) begin
                  start_in = sample;
                  open_in  = 1'b1;
               end
               if (run_ff != RUN_MAX) begin
                  run_in = run_ff + LEN_W'(1);
               end
            end else if (open_ff) begin
               evt_valid = 1'b1;
               run_in    = '0;
               start_in  = '0;
               open_in   = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         run_ff   <= '0;
         start_ff <= '0;
         open_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         run_ff   <= run_in;
         start_ff <= start_in;
         open_ff  <= open_in;
      end
   end

   assign evt.sample_index = count_ff;
   assign evt.run_length   = run_ff;
   assign evt.start_level  = start_ff;
   assign evt.end_level    = sample;

   assign status.fill  = fill;
   assign status.open  = open_ff;
   assign status.count = run_ff;

endmodule

`default_nettype wire

>>> rtl/dsed_out_buf.sv
// ----------------------------------------------------------------------------
// dsed_out_buf
// Output register with a skid entry behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module dsed_out_buf (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              evt_valid,
   input  dsed_pkg::evt_type      evt,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid,
   output dsed_pkg::evt_type      rsp_evt,
   output logic                   full
);
   import dsed_pkg::*;

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   evt_type out_ff, out_in;
   evt_type skid_ff, skid_in;
   logic    take;

   assign take = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // input is stalled while the skid entry is held
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (evt_valid) begin
         if (!out_valid_ff || take) begin
            out_in       = evt;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = evt;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_evt   = out_ff;
   assign full      = skid_valid_ff;

endmodule

`default_nettype wire
